### sv/srpm_pkg.sv
// ----------------------------------------------------------------------------
// srpm_pkg
// Shared types and constants of the stereo RMS / peak level meter.
// ----------------------------------------------------------------------------
package srpm_pkg;

    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 24;

    localparam int LEVEL_W  = SAMPLE_BITS - 1;          // Q0.23 level
    localparam int SQ_W     = 2 * SAMPLE_BITS;          // one square
    localparam int SUM_W    = 59;                       // sum of squares
    localparam int CNT_W    = 13;                       // sample count
    localparam int ROOT_W   = (SUM_W + 1) / 2;          // root of the mean
    localparam int RAD_W    = 2 * ROOT_W;               // padded radicand
    localparam int REM_W    = ROOT_W + 2;               // root remainder
    localparam int CREST_W  = 16;
    localparam int PROD_W   = CREST_W + LEVEL_W;        // crest * rms
    localparam int STEP_W   = $clog2(SUM_W + 1);
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    // register map, word index
    localparam logic [1:0] REG_ACTIVE = 2'd0;
    localparam logic [1:0] REG_CLIP   = 2'd1;
    localparam logic [1:0] REG_HOT    = 2'd2;
    localparam logic [1:0] REG_CREST  = 2'd3;

    localparam logic [1:0]         ACTIVE_RST = 2'd2;
    localparam logic [LEVEL_W-1:0] CLIP_RST   = 23'd8380219;
    localparam logic [LEVEL_W-1:0] HOT_RST    = 23'd6291456;
    localparam logic [CREST_W-1:0] CREST_RST  = 16'd2048;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_left;
        logic signed [SAMPLE_BITS-1:0] sample_right;
        logic                          last_sample;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] rms_left;
        logic [LEVEL_W-1:0] peak_left;
        logic               clip_left;
        logic               hot_left;
        logic [LEVEL_W-1:0] rms_right;
        logic [LEVEL_W-1:0] peak_right;
        logic               clip_right;
        logic               hot_right;
    } out_item_t;

    typedef struct packed {
        logic [1:0]         active_channels;
        logic [LEVEL_W-1:0] clip_threshold;
        logic [LEVEL_W-1:0] hot_threshold;
        logic [CREST_W-1:0] crest_limit;
    } cfg_t;

    // finished block waiting for the back end
    typedef struct packed {
        logic [1:0][SUM_W-1:0]   sum;
        logic [1:0][LEVEL_W-1:0] peak;
        logic [CNT_W-1:0]        count;
    } blk_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_ROOT,
        BK_FLAG,
        BK_OUT
    } bk_state_t;

endpackage

### sv/srpm_front.sv
// ----------------------------------------------------------------------------
// srpm_front
// Squares incoming sample pairs and accumulates sums, peaks and count; hands
// each finished block to the queue.
// ----------------------------------------------------------------------------
module srpm_front import srpm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  in_item_t s_data,
    input  logic     s_fire,
    output logic     pend,
    output logic     push,
    output blk_t     push_data
);

    logic                          a_valid_reg;
    logic                          a_last_reg;
    logic [1:0][SQ_W-1:0]          a_sq_reg;
    logic [1:0][SAMPLE_BITS-1:0]   a_smp_reg;

    logic [1:0][SUM_W-1:0]         sum_reg;
    logic [1:0][LEVEL_W-1:0]       peak_reg;
    logic [CNT_W-1:0]              cnt_reg;

    logic [1:0][SAMPLE_BITS-1:0]   smp_in;
    logic [1:0][SAMPLE_BITS-1:0]   mag;
    logic [1:0][SUM_W:0]           sum_wide;
    logic [1:0][SUM_W-1:0]         sum_next;
    logic [1:0][LEVEL_W-1:0]       peak_next;
    logic [CNT_W-1:0]              cnt_next;

    assign smp_in[0] = s_data.sample_left;
    assign smp_in[1] = s_data.sample_right;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            mag[i] = smp_in[i][SAMPLE_BITS-1] ? (~smp_in[i] + 1'b1) : smp_in[i];
        end
    end

    // stage A: square
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= s_fire;
        end
        if (s_fire) begin
            a_last_reg <= s_data.last_sample;
            for (int i = 0; i < 2; i++) begin
                a_sq_reg[i]  <= mag[i] * mag[i];
                a_smp_reg[i] <= smp_in[i];
            end
        end
    end

    // stage B: accumulate with saturation
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            sum_wide[i] = {1'b0, sum_reg[i]} + {{(SUM_W + 1 - SQ_W){1'b0}}, a_sq_reg[i]};
            sum_next[i] = sum_wide[i][SUM_W] ? SUM_MAX : sum_wide[i][SUM_W-1:0];
            // negative samples never raise the peak
            if (!a_smp_reg[i][SAMPLE_BITS-1] && (a_smp_reg[i][LEVEL_W-1:0] > peak_reg[i])) begin
                peak_next[i] = a_smp_reg[i][LEVEL_W-1:0];
            end else begin
                peak_next[i] = peak_reg[i];
            end
        end
        cnt_next = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            peak_reg <= '0;
            cnt_reg  <= '0;
        end else if (a_valid_reg) begin
            if (a_last_reg) begin
                sum_reg  <= '0;
                peak_reg <= '0;
                cnt_reg  <= '0;
            end else begin
                sum_reg  <= sum_next;
                peak_reg <= peak_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    assign pend            = a_valid_reg & a_last_reg;
    assign push            = pend;
    assign push_data.sum   = sum_next;
    assign push_data.peak  = peak_next;
    assign push_data.count = cnt_next;

endmodule

### sv/srpm_queue.sv
// ----------------------------------------------------------------------------
// srpm_queue
// Short queue of finished blocks between the accumulator and the back end.
// ----------------------------------------------------------------------------
module srpm_queue import srpm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  blk_t              push_data,
    input  logic              pop,
    output blk_t              head,
    output logic              empty,
    output logic [QCNT_W-1:0] count
);

    blk_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;

endmodule

### sv/srpm_back.sv
// ----------------------------------------------------------------------------
// srpm_back
// Per block and lane: bit-serial mean division, bit-serial square root,
// clip and crest tests; holds the result in the output register.
// ----------------------------------------------------------------------------
module srpm_back import srpm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  blk_t      q_head,
    input  logic      q_empty,
    output logic      q_pop,
    input  logic      m_ready,
    output logic      m_valid,
    output out_item_t m_data
);

    bk_state_t           state_reg, state_next;
    logic                lane_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;
    out_item_t           res_reg;

    logic [SUM_W-1:0]    div_q_reg;
    logic [CNT_W-1:0]    div_r_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic                right_on;
    logic                out_free;
    logic                div_done;
    logic                root_done;
    logic                load_out;

    logic [CNT_W:0]      div_trial;
    logic                div_ge;
    logic [REM_W+1:0]    rt_shift;
    logic [REM_W+1:0]    rt_trial;
    logic                rt_ge;

    logic [LEVEL_W-1:0]  rms_sat;
    logic [LEVEL_W-1:0]  pk_sel;
    logic [PROD_W-1:0]   crest_prod;
    logic                clip_f;
    logic                hot_f;

    assign right_on = (CHANNELS >= 2) && (cfg.active_channels >= 2'd2);
    assign out_free = !m_valid_reg || m_ready;
    assign div_done  = (step_reg == STEP_W'(SUM_W - 1));
    assign root_done = (step_reg == STEP_W'(ROOT_W - 1));

    // restoring division step
    always_comb begin
        div_trial = {div_r_reg, div_q_reg[SUM_W-1]};
        div_ge    = (div_trial >= {1'b0, q_head.count});
    end

    // square root digit step, two radicand bits per cycle
    always_comb begin
        rt_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        rt_trial = {{(REM_W + 2 - ROOT_W - 2){1'b0}}, root_reg, 2'b01};
        rt_ge    = (rt_shift >= rt_trial);
    end

    always_comb begin
        rms_sat    = (|root_reg[ROOT_W-1:LEVEL_W]) ? LEVEL_MAX : root_reg[LEVEL_W-1:0];
        pk_sel     = q_head.peak[lane_reg];
        crest_prod = PROD_W'(cfg.crest_limit) * PROD_W'(rms_sat);
        clip_f     = (pk_sel > cfg.clip_threshold);
        hot_f      = (pk_sel > cfg.hot_threshold)
                     && ({{(PROD_W - LEVEL_W - 8){1'b0}}, pk_sel, 8'd0} > crest_prod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    state_next = BK_ROOT;
                end
            end
            BK_ROOT: begin
                if (root_done) begin
                    state_next = BK_FLAG;
                end
            end
            BK_FLAG: begin
                state_next = (!lane_reg && right_on) ? BK_DIV : BK_OUT;
            end
            BK_OUT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    q_pop      = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // lane and step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            case (state_reg)
                BK_IDLE: begin
                    lane_reg <= 1'b0;
                    step_reg <= '0;
                end
                BK_DIV:  step_reg <= div_done ? '0 : step_reg + 1'b1;
                BK_ROOT: step_reg <= root_done ? '0 : step_reg + 1'b1;
                BK_FLAG: lane_reg <= 1'b1;
                default: step_reg <= '0;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                div_q_reg <= q_head.sum[0];
                div_r_reg <= '0;
            end
            BK_DIV: begin
                div_q_reg <= {div_q_reg[SUM_W-2:0], div_ge};
                div_r_reg <= div_ge ? CNT_W'(div_trial - {1'b0, q_head.count})
                                    : div_trial[CNT_W-1:0];
                if (div_done) begin
                    rad_reg  <= {{(RAD_W - SUM_W){1'b0}}, div_q_reg[SUM_W-2:0], div_ge};
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            BK_ROOT: begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                rem_reg  <= rt_ge ? REM_W'(rt_shift - rt_trial) : REM_W'(rt_shift);
                root_reg <= {root_reg[ROOT_W-2:0], rt_ge};
            end
            BK_FLAG: begin
                if (!lane_reg) begin
                    res_reg.rms_left  <= rms_sat;
                    res_reg.peak_left <= pk_sel;
                    res_reg.clip_left <= clip_f;
                    res_reg.hot_left  <= hot_f;
                    // clear the right-lane fields; the right-lane pass overwrites them if it runs
                    res_reg.rms_right  <= '0;
                    res_reg.peak_right <= '0;
                    res_reg.clip_right <= 1'b0;
                    res_reg.hot_right  <= 1'b0;
                    div_q_reg <= q_head.sum[1];
                    div_r_reg <= '0;
                end else begin
                    res_reg.rms_right  <= rms_sat;
                    res_reg.peak_right <= pk_sel;
                    res_reg.clip_right <= clip_f;
                    res_reg.hot_right  <= hot_f;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (load_out) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### sv/stereo_rms_peak_meter.sv
// ----------------------------------------------------------------------------
// stereo_rms_peak_meter
// Stereo RMS and peak level meter with clip and crest-factor flags.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one stereo Q1.23 sample pair per item, last_sample marks the
//   end of a block. Items are taken every cycle while s_ready is high.
//   m_ channel: one result item per block, with RMS, peak, clip and hot
//   flags for each lane; the right lane reads zero when active_channels < 2.
//   APB port: four word registers (active_channels, clip_threshold,
//   hot_threshold, crest_limit), pready tied high; write only while idle.
// Processing and throughput:
//   m_valid rises once the 59-step serial divider and the 30-step serial
//   square root, shared by both lanes, have run for the left lane and, when
//   on, the right lane of a block whose last item was taken.
//   Sample pairs stream at one per cycle while s_ready is high; the queue holds
//   the back end's block plus one finished block, so short blocks stall s_ready.
// Reset (aresetn low, synchronous): sums, peaks, count and queue clear,
//   registers return to defaults, m_valid drops.
// A stalled m_ready holds the result; the front keeps accumulating until
//   the block queue fills.
// ----------------------------------------------------------------------------
module stereo_rms_peak_meter import srpm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t              cfg_reg;
    logic              cfg_wr;
    logic [1:0]        reg_idx;

    logic              s_fire;
    logic              pend;
    logic              push;
    blk_t              push_data;
    logic              q_pop;
    blk_t              q_head;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_channels <= ACTIVE_RST;
            cfg_reg.clip_threshold  <= CLIP_RST;
            cfg_reg.hot_threshold   <= HOT_RST;
            cfg_reg.crest_limit     <= CREST_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ACTIVE: cfg_reg.active_channels <= pwdata[1:0];
                REG_CLIP:   cfg_reg.clip_threshold  <= pwdata[LEVEL_W-1:0];
                REG_HOT:    cfg_reg.hot_threshold   <= pwdata[LEVEL_W-1:0];
                REG_CREST:  cfg_reg.crest_limit     <= pwdata[CREST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ACTIVE: prdata = {{(DATA_W - 2){1'b0}}, cfg_reg.active_channels};
            REG_CLIP:   prdata = {{(DATA_W - LEVEL_W){1'b0}}, cfg_reg.clip_threshold};
            REG_HOT:    prdata = {{(DATA_W - LEVEL_W){1'b0}}, cfg_reg.hot_threshold};
            REG_CREST:  prdata = {{(DATA_W - CREST_W){1'b0}}, cfg_reg.crest_limit};
            default:    prdata = '0;
        endcase
    end

    // any item may close a block, so keep a queue slot for it
    assign s_ready = ({1'b0, q_count} + {{QCNT_W{1'b0}}, pend}) < (QCNT_W + 1)'(QDEPTH);
    assign s_fire  = s_valid & s_ready;

    srpm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .s_fire    (s_fire),
        .pend      (pend),
        .push      (push),
        .push_data (push_data)
    );

    srpm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .count     (q_count)
    );

    srpm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    a_queue_no_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_count < QCNT_W'(QDEPTH) || q_pop))
        else $error("block queue overflow");

    a_queue_no_underflow : assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from empty block queue");

    a_right_lane_off : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cfg_reg.active_channels < 2'd2) |->
        (m_data.rms_right == '0 && m_data.peak_right == '0
         && !m_data.clip_right && !m_data.hot_right))
        else $error("right lane not zero with one channel active");

    a_clip_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.clip_left == (m_data.peak_left > cfg_reg.clip_threshold)))
        else $error("clip flag does not match peak");

endmodule

### test/srpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpm_checker
// Watches the sample, result and register ports of the level meter, predicts
// every block result from the accepted sample pairs and compares it field by
// field with the result the block hands out.
// ----------------------------------------------------------------------------
module srpm_checker import srpm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_item_t          s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                fail_count,
    output int                pending,
    output int                pairs_seen,
    output int                blocks_seen
);

    typedef struct packed {
        logic [LEVEL_W-1:0] rms;
        logic [LEVEL_W-1:0] peak;
        logic               clip;
        logic               hot;
    } lane_meter_t;

    logic [SUM_W-1:0]   sq_sum    [2];
    logic [LEVEL_W-1:0] peak_hold [2];
    logic [CNT_W-1:0]   pair_count;
    cfg_t               cfg;
    out_item_t          meter_q [$];
    int                 mismatches;
    int                 n_pairs;
    int                 n_blocks;

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = v;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic void accumulate(input int lane, input logic signed [SAMPLE_BITS-1:0] smp);
        logic [63:0] mag;
        logic [63:0] sq;
        mag = smp[SAMPLE_BITS-1] ? (64'd1 << SAMPLE_BITS) - 64'(smp[SAMPLE_BITS-1:0])
                                 : 64'(smp[SAMPLE_BITS-1:0]);
        sq  = mag * mag;
        // saturate the sum of squares
        if (sq > 64'(SUM_MAX) - 64'(sq_sum[lane]))
            sq_sum[lane] = SUM_MAX;
        else
            sq_sum[lane] = sq_sum[lane] + sq[SUM_W-1:0];
        // negative samples never raise the peak
        if (!smp[SAMPLE_BITS-1] && smp[LEVEL_W-1:0] > peak_hold[lane])
            peak_hold[lane] = smp[LEVEL_W-1:0];
    endfunction

    function automatic lane_meter_t lane_levels(input int lane);
        logic [63:0] mean;
        logic [63:0] root;
        logic [63:0] lhs;
        logic [63:0] rhs;
        lane_meter_t lm;
        mean = 64'(sq_sum[lane]) / 64'(pair_count);
        root = floor_root(mean);
        if (root > 64'(LEVEL_MAX))
            root = 64'(LEVEL_MAX);
        lhs     = 64'(peak_hold[lane]) << 8;
        rhs     = 64'(cfg.crest_limit) * root;
        lm.rms  = root[LEVEL_W-1:0];
        lm.peak = peak_hold[lane];
        lm.clip = peak_hold[lane] > cfg.clip_threshold;
        lm.hot  = (peak_hold[lane] > cfg.hot_threshold) && (lhs > rhs);
        return lm;
    endfunction

    function automatic out_item_t close_block();
        out_item_t   res;
        lane_meter_t lm;
        lm             = lane_levels(0);
        res.rms_left   = lm.rms;
        res.peak_left  = lm.peak;
        res.clip_left  = lm.clip;
        res.hot_left   = lm.hot;
        if (CHANNELS >= 2 && cfg.active_channels >= 2'd2) begin
            lm = lane_levels(1);
        end else begin
            lm = '0;
        end
        res.rms_right  = lm.rms;
        res.peak_right = lm.peak;
        res.clip_right = lm.clip;
        res.hot_right  = lm.hot;
        sq_sum[0]      = '0;
        sq_sum[1]      = '0;
        peak_hold[0]   = '0;
        peak_hold[1]   = '0;
        pair_count     = '0;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        string     bad;
        if (!aresetn) begin
            sq_sum[0]    = '0;
            sq_sum[1]    = '0;
            peak_hold[0] = '0;
            peak_hold[1] = '0;
            pair_count   = '0;
            cfg          = '{ACTIVE_RST, CLIP_RST, HOT_RST, CREST_RST};
            meter_q.delete();
            mismatches   = 0;
            n_pairs      = 0;
            n_blocks     = 0;
        end else begin
            // compare before predicting: a result is always from an older block
            if (m_valid && m_ready) begin
                n_blocks++;
                if (meter_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result item with none expected: %h", $time, m_data);
                end else begin
                    want = meter_q.pop_front();
                    bad  = "";
                    if (m_data.rms_left   !== want.rms_left)   bad = {bad, " rms_left"};
                    if (m_data.peak_left  !== want.peak_left)  bad = {bad, " peak_left"};
                    if (m_data.clip_left  !== want.clip_left)  bad = {bad, " clip_left"};
                    if (m_data.hot_left   !== want.hot_left)   bad = {bad, " hot_left"};
                    if (m_data.rms_right  !== want.rms_right)  bad = {bad, " rms_right"};
                    if (m_data.peak_right !== want.peak_right) bad = {bad, " peak_right"};
                    if (m_data.clip_right !== want.clip_right) bad = {bad, " clip_right"};
                    if (m_data.hot_right  !== want.hot_right)  bad = {bad, " hot_right"};
                    if (bad != "") begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: block %0d mismatch in%s", $time, n_blocks, bad);
                            $display("  expected L %0d %0d %b %b  R %0d %0d %b %b",
                                     want.rms_left, want.peak_left, want.clip_left,
                                     want.hot_left, want.rms_right, want.peak_right,
                                     want.clip_right, want.hot_right);
                            $display("  actual   L %0d %0d %b %b  R %0d %0d %b %b",
                                     m_data.rms_left, m_data.peak_left, m_data.clip_left,
                                     m_data.hot_left, m_data.rms_right, m_data.peak_right,
                                     m_data.clip_right, m_data.hot_right);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                n_pairs++;
                accumulate(0, s_data.sample_left);
                accumulate(1, s_data.sample_right);
                if (pair_count != CNT_MAX)
                    pair_count = pair_count + 1'b1;
                if (s_data.last_sample)
                    meter_q.push_back(close_block());
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ACTIVE: cfg.active_channels = pwdata[1:0];
                    REG_CLIP:   cfg.clip_threshold  = pwdata[LEVEL_W-1:0];
                    REG_HOT:    cfg.hot_threshold   = pwdata[LEVEL_W-1:0];
                    REG_CREST:  cfg.crest_limit     = pwdata[CREST_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count  <= mismatches;
        pending     <= meter_q.size();
        pairs_seen  <= n_pairs;
        blocks_seen <= n_blocks;
    end

endmodule

### test/tb_stereo_rms_peak_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_rms_peak_meter
// Streams directed and random stereo sample blocks through the level meter
// under a series of register settings, with random stalls on both channels,
// and leaves the result checking to srpm_checker.
// ----------------------------------------------------------------------------
module tb_stereo_rms_peak_meter;
    import srpm_pkg::*;

    localparam int LONG_HOLD      = 800;
    localparam int DRAIN_CYCLES   = 250;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 24'sh800000;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   fail_count;
    int   pending;
    int   pairs_seen;
    int   blocks_seen;
    int   settings     = 0;
    int   tx_calm      = 0;
    int   rx_hold      = 0;
    int   rx_calm      = 0;
    int   stall_cycles = 0;
    int   long_hold_seq  = 0;
    int   long_hold_seen = 0;
    logic quiet        = 1'b0;

    always #10 aclk = ~aclk;

    stereo_rms_peak_meter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    srpm_checker meter_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .pairs_seen  (pairs_seen),
        .blocks_seen (blocks_seen)
    );

    // result side: random stall bursts, calm stretches, one long hold on request
    always @(posedge aclk) begin : rx_side
        int pick;
        if (long_hold_seq != long_hold_seen) begin
            long_hold_seen <= long_hold_seq;
            rx_hold        <= LONG_HOLD;
            m_ready        <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_calm > 0 || quiet) begin
            if (rx_calm > 0)
                rx_calm <= rx_calm - 1;
            m_ready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
                rx_calm <= $urandom_range(30, 150);
                m_ready <= 1'b1;
            end else if (pick < 5) begin
                rx_hold <= $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_stereo_rms_peak_meter failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input in_item_t item);
        if (tx_calm > 0) begin
            tx_calm--;
        end else if (!quiet && $urandom_range(0, 49) == 0) begin
            tx_calm = $urandom_range(30, 150);
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] left,
                             input logic signed [SAMPLE_BITS-1:0] right,
                             input logic last);
        in_item_t item;
        item.sample_left  = left;
        item.sample_right = right;
        item.last_sample  = last;
        send_item(item);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int style);
        logic [31:0] w;
        w = $urandom();
        case (style)
            0: return w[SAMPLE_BITS-1:0];
            1: begin
                case ($urandom_range(0, 5))
                    0: return SMP_MAX;
                    1: return SMP_MIN;
                    2: return '0;
                    3: return 24'sd1;
                    4: return -24'sd1;
                    default: return SMP_MAX - 24'sd1;
                endcase
            end
            2: return SAMPLE_BITS'(int'($urandom_range(0, 8192)) - 4096);
            3: begin
                // mostly quiet with a rare spike: drives the crest test
                if (w[3:0] == 4'd0)
                    return SAMPLE_BITS'($urandom_range(4194304, 8388607));
                return SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
            end
            default: begin
                w = $urandom_range(6000000, 8388607);
                return $urandom_range(0, 1) ? SAMPLE_BITS'(w) : -SAMPLE_BITS'(w);
            end
        endcase
    endfunction

    task automatic random_blocks(input int n);
        int sent;
        int len;
        int sel;
        int style_l;
        int style_r;
        sent = 0;
        while (sent < n) begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                len = $urandom_range(1, 8);
            else if (sel < 9)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 160);
            style_l = $urandom_range(0, 4);
            style_r = $urandom_range(0, 4);
            for (int i = 0; i < len; i++)
                send_pair(pick_sample(style_l), pick_sample(style_r), i == len - 1);
            sent += len;
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [1:0] act, input logic [LEVEL_W-1:0] clip,
                             input logic [LEVEL_W-1:0] hot, input logic [CREST_W-1:0] crest);
        apb_write(REG_ACTIVE, DATA_W'(act));
        apb_write(REG_CLIP,   DATA_W'(clip));
        apb_write(REG_HOT,    DATA_W'(hot));
        apb_write(REG_CREST,  DATA_W'(crest));
        settings++;
    endtask

    // drop valid, wait for every expected result, then let the back end drain
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_config();
        configure(2'($urandom_range(0, 3)), LEVEL_W'($urandom_range(0, 8388607)),
                  LEVEL_W'($urandom_range(0, 8388607)), CREST_W'($urandom_range(0, 3000)));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default registers: full scale, zero blocks, peak tracking
        send_pair(SMP_MAX, SMP_MIN, 1'b1);
        send_pair('0, '0, 1'b1);
        send_pair(-24'sd1, 24'sd1, 1'b0);
        send_pair(SMP_MIN, '0, 1'b0);
        send_pair(24'sd1, -24'sd1, 1'b1);
        send_pair(24'sd100, 24'sd200, 1'b0);
        send_pair(24'sd300, -24'sd5, 1'b0);
        send_pair(24'sd50, 24'sd7, 1'b1);
        send_pair(SMP_MAX - 24'sd1, SMP_MAX, 1'b0);
        send_pair(-24'sd100, SMP_MIN + 24'sd1, 1'b1);
        send_pair(24'sd7000000, 24'sd8000000, 1'b0);
        for (int i = 0; i < 4; i++)
            send_pair('0, '0, 1'b0);
        send_pair('0, '0, 1'b1);
        random_blocks(100);
        settle();

        // lowest thresholds, left lane only; zero root with a positive peak
        configure(2'd1, '0, '0, '0);
        send_pair(24'sd1, 24'sd1, 1'b0);
        send_pair('0, '0, 1'b1);
        send_pair(24'sd2, SMP_MAX, 1'b1);
        random_blocks(100);
        settle();

        configure(2'd3, LEVEL_MAX, LEVEL_MAX, 16'hFFFF);
        random_blocks(100);
        settle();

        // hold off the result side while short blocks keep coming
        configure(2'd0, 23'd4194304, 23'd2000000, 16'd512);
        long_hold_seq <= long_hold_seq + 1;
        for (int i = 0; i < 40; i++)
            send_pair(pick_sample(4), pick_sample(0), 1'b1);
        random_blocks(100);
        settle();

        // a long block near full scale, mostly negative so the peak stays low
        configure(2'd2, LEVEL_W'($urandom_range(0, 8388607)),
                  LEVEL_W'($urandom_range(0, 4000000)), CREST_W'($urandom_range(0, 1024)));
        for (int i = 0; i < 200; i++)
            send_pair((i % 50 == 7) ? pick_sample(1) : SMP_MIN, SMP_MIN, i == 199);
        random_blocks(100);
        settle();

        random_config();
        random_blocks(100);
        settle();
        random_config();
        random_blocks(100);
        settle();

        // no idling on either side from here on
        quiet <= 1'b1;
        configure(2'd2, LEVEL_W'($urandom_range(0, 8388607)),
                  LEVEL_W'($urandom_range(0, 8388607)), CREST_W'($urandom_range(0, 3000)));
        random_blocks(100);
        settle();

        $display("run covered %0d sample pairs in %0d metered blocks over %0d register settings",
                 pairs_seen, blocks_seen, settings);
        $display("including a long full-scale block, a %0d-cycle result stall and all lane modes",
                 LONG_HOLD);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_stereo_rms_peak_meter passed");
        end else begin
            $display("tb_stereo_rms_peak_meter failed");
        end
        $finish;
    end

endmodule
